[design/braille_chord_accumulator_defines.svh]
// Assertion macros shared by the braille chord accumulator RTL.
// Included by bca_dpath, which carries the concurrent assertions; no other dependencies.
`ifndef BRAILLE_CHORD_ACCUMULATOR_DEFINES_SVH
`define BRAILLE_CHORD_ACCUMULATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock edge, off while reset is low.
`define BCA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bca assertion failed");
// Next-cycle implication, sampled on the rising clock edge, off while reset is low.
`define BCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bca assertion failed");
`else
`define BCA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BCA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[design/bca_pkg.sv]
// Package for the braille chord accumulator: key codes, state and command types.
// Depends on nothing; used by the interfaces' users, the controller and the datapath.
package bca_pkg;

  localparam int unsigned LIST_DEPTH = 16;

  localparam logic [6:0] ROUTE_LO   = 7'h20;
  localparam logic [6:0] ROUTE_END  = 7'h48;
  localparam logic [4:0] CODE_SPACE = 5'h10;

  localparam logic [4:0] CODE_DOT1 = 5'h0F;
  localparam logic [4:0] CODE_DOT2 = 5'h0B;
  localparam logic [4:0] CODE_DOT3 = 5'h07;
  localparam logic [4:0] CODE_DOT4 = 5'h13;
  localparam logic [4:0] CODE_DOT5 = 5'h17;
  localparam logic [4:0] CODE_DOT6 = 5'h1B;
  localparam logic [4:0] CODE_DOT7 = 5'h03;
  localparam logic [4:0] CODE_DOT8 = 5'h1F;

  localparam logic [4:0] CODE_NAV_A = 5'h04;
  localparam logic [4:0] CODE_NAV_B = 5'h08;
  localparam logic [4:0] CODE_NAV_C = 5'h0C;
  localparam logic [4:0] CODE_NAV_D = 5'h14;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_PRESS,
    ST_COMMIT,
    ST_SCAN_REL,
    ST_REL_READ,
    ST_REL_WRITE,
    ST_REL_CHECK,
    ST_SCAN_CHORD,
    ST_EMIT_ROUTE,
    ST_EMIT_CHORD
  } bca_state_e;

  typedef enum logic [2:0] {
    CLS_CLEAR,
    CLS_DROP,
    CLS_ROUTE_PRESS,
    CLS_CHORD_PRESS,
    CLS_CHORD_RELEASE
  } bca_cls_e;

  typedef enum logic [1:0] {
    SCAN_PRESS,
    SCAN_RELEASE,
    SCAN_CHORD
  } bca_scan_e;

  typedef struct packed {
    logic      capture;
    logic      clear_all;
    logic      scan_start;
    logic      scan_step;
    bca_scan_e scan_mode;
    logic      commit_press;
    logic      rel_read;
    logic      rel_write;
    logic      load_route;
    logic      load_chord;
  } bca_cmd_t;

  typedef struct packed {
    bca_cls_e cls;
    logic     scan_done;
    logic     held_hit;
    logic     held_empty;
    logic     chord_empty;
    logic     out_free;
  } bca_stat_t;

  // One-hot dot bit for a chord key code, zero when the code is not a dot key.
  function automatic logic [7:0] dot_mask_of(input logic [4:0] code);
    logic [7:0] m;
    m = 8'h00;
    case (code)
      CODE_DOT1: m = 8'h01;
      CODE_DOT2: m = 8'h02;
      CODE_DOT3: m = 8'h04;
      CODE_DOT4: m = 8'h08;
      CODE_DOT5: m = 8'h10;
      CODE_DOT6: m = 8'h20;
      CODE_DOT7: m = 8'h40;
      CODE_DOT8: m = 8'h80;
      default:   m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic is_nav(input logic [4:0] code);
    return (code == CODE_NAV_A) || (code == CODE_NAV_B) ||
           (code == CODE_NAV_C) || (code == CODE_NAV_D);
  endfunction

endpackage

[design/bca_in_if.sv]
// Input channel of the braille chord accumulator: valid/ready plus one key event.
// Self-contained; no package needed.
interface bca_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] key_byte;

  modport source (output valid, output command, output key_byte, input ready);
  modport sink   (input valid, input command, input key_byte, output ready);
endinterface

[design/bca_out_if.sv]
// Result channel of the braille chord accumulator: valid/ready plus one result.
// Self-contained; no package needed.
interface bca_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] dot_mask;
  logic       space_pressed;
  logic [4:0] nav_code;
  logic [5:0] routing_index;

  modport source (output valid, output result_kind, output dot_mask, output space_pressed,
                  output nav_code, output routing_index, input ready);
  modport sink   (input valid, input result_kind, input dot_mask, input space_pressed,
                  input nav_code, input routing_index, output ready);
endinterface

[design/bca_ctrl.sv]
// Sequencer of the braille chord accumulator: walks one key event through its steps.
// Depends on bca_pkg for the state, command and status types.
module bca_ctrl
  import bca_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  bca_stat_t stat_i,
  output logic      in_ready_o,
  output bca_cmd_t  cmd_o
);

  bca_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (stat_i.cls)
          CLS_CLEAR:         state_d = ST_IDLE;
          CLS_DROP:          state_d = ST_IDLE;
          CLS_ROUTE_PRESS:   state_d = ST_EMIT_ROUTE;
          CLS_CHORD_PRESS:   state_d = ST_SCAN_PRESS;
          CLS_CHORD_RELEASE: state_d = ST_SCAN_REL;
          default:           state_d = ST_IDLE;
        endcase
      end
      ST_SCAN_PRESS: begin
        if (stat_i.scan_done) state_d = ST_COMMIT;
      end
      ST_COMMIT: state_d = ST_IDLE;
      ST_SCAN_REL: begin
        if (stat_i.scan_done) state_d = stat_i.held_hit ? ST_REL_READ : ST_REL_CHECK;
      end
      ST_REL_READ:  state_d = ST_REL_WRITE;
      ST_REL_WRITE: state_d = ST_REL_CHECK;
      ST_REL_CHECK: begin
        state_d = (stat_i.held_empty && !stat_i.chord_empty) ? ST_SCAN_CHORD : ST_IDLE;
      end
      ST_SCAN_CHORD: begin
        if (stat_i.scan_done) state_d = ST_EMIT_CHORD;
      end
      ST_EMIT_ROUTE: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      ST_EMIT_CHORD: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.scan_mode = SCAN_PRESS;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.clear_all  = (stat_i.cls == CLS_CLEAR);
        cmd_o.scan_start = (stat_i.cls == CLS_CHORD_PRESS) ||
                           (stat_i.cls == CLS_CHORD_RELEASE);
      end
      ST_SCAN_PRESS: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.scan_mode = SCAN_PRESS;
      end
      ST_COMMIT: cmd_o.commit_press = 1'b1;
      ST_SCAN_REL: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.scan_mode = SCAN_RELEASE;
      end
      ST_REL_READ:  cmd_o.rel_read = 1'b1;
      ST_REL_WRITE: cmd_o.rel_write = 1'b1;
      ST_REL_CHECK: cmd_o.scan_start = stat_i.held_empty && !stat_i.chord_empty;
      ST_SCAN_CHORD: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.scan_mode = SCAN_CHORD;
      end
      ST_EMIT_ROUTE: cmd_o.load_route = stat_i.out_free;
      ST_EMIT_CHORD: cmd_o.load_chord = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

[design/bca_dpath.sv]
// Datapath of the braille chord accumulator: held and chord key lists, scan, result register.
// Depends on bca_pkg and on the assertion macros in the defines header.
`include "braille_chord_accumulator_defines.svh"

module bca_dpath
  import bca_pkg::*;
#(
  parameter int unsigned Depth = LIST_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bca_cmd_t   cmd_i,
  output bca_stat_t  stat_o,
  input  logic       command_i,
  input  logic [7:0] key_byte_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic       result_kind_o,
  output logic [7:0] dot_mask_o,
  output logic       space_pressed_o,
  output logic [4:0] nav_code_o,
  output logic [5:0] routing_index_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned IdxW = $clog2(Depth);
  localparam logic [CntW-1:0] CntMax = CntW'(Depth);

  logic [4:0] held_mem  [Depth];
  logic [4:0] chord_mem [Depth];

  logic            command_q;
  logic [7:0]      byte_q;
  logic [CntW-1:0] held_cnt_q, chord_cnt_q;
  logic [CntW-1:0] idx_q;
  logic            rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;
  logic [4:0]      held_rd_q, chord_rd_q;
  logic            held_hit_q, chord_hit_q;
  logic [IdxW-1:0] held_pos_q;
  logic [7:0]      mask_q;
  logic            space_q;
  logic [4:0]      nav_q;

  logic            out_valid_q;
  logic            out_kind_q;
  logic [7:0]      out_mask_q;
  logic            out_space_q;
  logic [4:0]      out_nav_q;
  logic [5:0]      out_route_q;

  logic [6:0]      code7;
  logic [4:0]      code5;
  logic            is_release;
  bca_cls_e        cls;
  logic [CntW-1:0] scan_len;
  logic            issue;
  logic [IdxW-1:0] held_raddr;
  logic            rd_in_held, rd_in_chord;
  logic            out_free;

  assign code7      = byte_q[6:0];
  assign code5      = byte_q[4:0];
  assign is_release = byte_q[7];

  always_comb begin
    priority if (command_q) begin
      cls = CLS_CLEAR;
    end else if (code7 >= ROUTE_END) begin
      cls = CLS_DROP;
    end else if (code7 >= ROUTE_LO) begin
      cls = is_release ? CLS_DROP : CLS_ROUTE_PRESS;
    end else begin
      cls = is_release ? CLS_CHORD_RELEASE : CLS_CHORD_PRESS;
    end
  end

  always_comb begin
    unique case (cmd_i.scan_mode)
      SCAN_PRESS:   scan_len = (held_cnt_q > chord_cnt_q) ? held_cnt_q : chord_cnt_q;
      SCAN_RELEASE: scan_len = held_cnt_q;
      SCAN_CHORD:   scan_len = chord_cnt_q;
      default:      scan_len = '0;
    endcase
  end

  assign issue       = cmd_i.scan_step && (idx_q < scan_len);
  assign held_raddr  = cmd_i.rel_read ? IdxW'(held_cnt_q - 1'b1) : idx_q[IdxW-1:0];
  assign rd_in_held  = rd_vld_q && (CntW'(rd_idx_q) < held_cnt_q);
  assign rd_in_chord = rd_vld_q && (CntW'(rd_idx_q) < chord_cnt_q);
  assign out_free    = !out_valid_q || out_ready_i;

  assign stat_o.cls         = cls;
  assign stat_o.scan_done   = (idx_q >= scan_len) && !rd_vld_q;
  assign stat_o.held_hit    = held_hit_q;
  assign stat_o.held_empty  = (held_cnt_q == '0);
  assign stat_o.chord_empty = (chord_cnt_q == '0);
  assign stat_o.out_free    = out_free;

  // Key lists: one write and one registered read each per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_press && !held_hit_q && (held_cnt_q < CntMax)) begin
      held_mem[held_cnt_q[IdxW-1:0]] <= code5;
    end else if (cmd_i.rel_write) begin
      held_mem[held_pos_q] <= held_rd_q;
    end
    if (cmd_i.commit_press && !chord_hit_q && (chord_cnt_q < CntMax)) begin
      chord_mem[chord_cnt_q[IdxW-1:0]] <= code5;
    end
    held_rd_q  <= held_mem[held_raddr];
    chord_rd_q <= chord_mem[idx_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      command_q <= command_i;
      byte_q    <= key_byte_i;
    end
    rd_idx_q <= idx_q[IdxW-1:0];
    if (cmd_i.scan_start) begin
      mask_q  <= 8'h00;
      space_q <= 1'b0;
      nav_q   <= 5'd0;
    end else if (rd_in_chord) begin
      mask_q <= mask_q | dot_mask_of(chord_rd_q);
      if (chord_rd_q == CODE_SPACE) space_q <= 1'b1;
      if (is_nav(chord_rd_q)) nav_q <= chord_rd_q;
    end
    if (rd_in_held && (held_rd_q == code5)) held_pos_q <= rd_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      held_hit_q  <= 1'b0;
      chord_hit_q <= 1'b0;
      held_cnt_q  <= '0;
      chord_cnt_q <= '0;
    end else begin
      if (cmd_i.scan_start) begin
        idx_q       <= '0;
        rd_vld_q    <= 1'b0;
        held_hit_q  <= 1'b0;
        chord_hit_q <= 1'b0;
      end else begin
        if (issue) idx_q <= idx_q + 1'b1;
        rd_vld_q <= issue;
        if (rd_in_held && (held_rd_q == code5)) held_hit_q <= 1'b1;
        if (rd_in_chord && (chord_rd_q == code5)) chord_hit_q <= 1'b1;
      end
      if (cmd_i.clear_all) begin
        held_cnt_q  <= '0;
        chord_cnt_q <= '0;
      end else begin
        if (cmd_i.commit_press && !held_hit_q && (held_cnt_q < CntMax)) begin
          held_cnt_q <= held_cnt_q + 1'b1;
        end else if (cmd_i.rel_write) begin
          held_cnt_q <= held_cnt_q - 1'b1;
        end
        if (cmd_i.commit_press && !chord_hit_q && (chord_cnt_q < CntMax)) begin
          chord_cnt_q <= chord_cnt_q + 1'b1;
        end else if (cmd_i.load_chord) begin
          chord_cnt_q <= '0;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_route || cmd_i.load_chord) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_route) begin
      out_kind_q  <= 1'b1;
      out_mask_q  <= 8'h00;
      out_space_q <= 1'b0;
      out_nav_q   <= 5'd0;
      out_route_q <= 6'(code7 - ROUTE_LO);
    end else if (cmd_i.load_chord) begin
      out_kind_q  <= 1'b0;
      out_mask_q  <= mask_q;
      out_space_q <= space_q;
      out_nav_q   <= nav_q;
      out_route_q <= 6'd0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_kind_q;
  assign dot_mask_o      = out_mask_q;
  assign space_pressed_o = out_space_q;
  assign nav_code_o      = out_nav_q;
  assign routing_index_o = out_route_q;

  `BCA_ASSERT_IMPL(a_held_cap, clk_i, rst_ni, 1'b1, held_cnt_q <= CntMax)
  `BCA_ASSERT_NEXT(a_chord_cleared, clk_i, rst_ni, cmd_i.load_chord, chord_cnt_q == '0)
  `BCA_ASSERT_NEXT(a_held_step, clk_i, rst_ni, !cmd_i.clear_all,
                   (held_cnt_q == $past(held_cnt_q)) ||
                   (held_cnt_q == $past(held_cnt_q) + 1'b1) ||
                   (held_cnt_q == $past(held_cnt_q) - 1'b1))
  `BCA_ASSERT_IMPL(a_load_free, clk_i, rst_ni, cmd_i.load_route || cmd_i.load_chord,
                   !out_valid_q || out_ready_i)

endmodule

[design/braille_chord_accumulator.sv]
// Top level of the braille chord accumulator: joins the sequencer and the datapath.
// Depends on bca_pkg, bca_in_if, bca_out_if, bca_ctrl and bca_dpath.
//
//   Channel | Direction | Payload
//   in_i    | sink      | command, key_byte
//   out_o   | source    | result_kind, dot_mask, space_pressed, nav_code, routing_index
//
// One key event is handled at a time; the input is ready only while the sequencer is idle.
// After a transfer the sequencer walks the key lists, one registered read of the key
// memories per cycle. A chord key press scans both lists and commits the key to each
// list that lacks it and has room. A release scans the held keys, moves the last held
// entry into the released key's slot if it was held, and once no key is held with a chord
// open, scans the chord list and emits the chord. Routing presses are emitted directly.
// Reset empties both key lists at once through their counts; no clearing pass is needed.
// A result waits in the output register while the next event is taken in; only a second
// result meeting a full, stalled output register holds the sequencer until its transfer.
module braille_chord_accumulator
  import bca_pkg::*;
#(
  parameter int unsigned ListDepth = LIST_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bca_in_if.sink    in_i,
  bca_out_if.source out_o
);

  // Commands from the sequencer to the datapath and status back.
  bca_cmd_t  cmd;
  bca_stat_t stat;
  logic      in_ready;

  bca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .stat_i     (stat),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  // The datapath keeps the held set and the press-ordered chord list in small memories,
  // walks them to find duplicates and to build the dot mask, and owns the output register.
  bca_dpath #(
    .Depth (ListDepth)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .command_i       (in_i.command),
    .key_byte_i      (in_i.key_byte),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .result_kind_o   (out_o.result_kind),
    .dot_mask_o      (out_o.dot_mask),
    .space_pressed_o (out_o.space_pressed),
    .nav_code_o      (out_o.nav_code),
    .routing_index_o (out_o.routing_index)
  );

  assign in_i.ready = in_ready;

endmodule

[bench/tb_braille_chord_accumulator.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the braille chord accumulator: key events in, chord and
// routing results out. Depends on bca_pkg, bca_in_if, bca_out_if and the top level.
module tb_braille_chord_accumulator;
  import bca_pkg::*;

  // Command and result kind encodings of the two channels.
  localparam logic CMD_KEY    = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;
  localparam logic KIND_CHORD = 1'b0;
  localparam logic KIND_ROUTE = 1'b1;

  // Bit 7 of a key byte marks a release.
  localparam logic [7:0] KEY_RELEASE = 8'h80;
  localparam logic [6:0] CODE_TOP    = 7'h7F;

  // Low codes that have no meaning in a chord; they only keep it open.
  localparam logic [4:0] KEY_UNMAPPED_A = 5'h00;
  localparam logic [4:0] KEY_UNMAPPED_B = 5'h01;

  localparam int unsigned NAMED_COUNT = 13;
  localparam logic [4:0] NAMED_KEYS [NAMED_COUNT] = '{
    CODE_DOT1, CODE_DOT2, CODE_DOT3, CODE_DOT4, CODE_DOT5, CODE_DOT6, CODE_DOT7,
    CODE_DOT8, CODE_SPACE, CODE_NAV_A, CODE_NAV_B, CODE_NAV_C, CODE_NAV_D
  };

  // Cycles without any transfer on either channel before the run is declared hung.
  // The slowest event, the longest sender gap and the longest receiver stall together
  // stay below this limit, so it leaves a wide margin.
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES  = 64;
  localparam int unsigned RANDOM_EVENTS = 1000;

  typedef struct packed {
    logic       kind;
    logic [7:0] dots;
    logic       space;
    logic [4:0] nav;
    logic [5:0] route;
  } key_result_t;

  logic clk;
  logic rst_n;

  bca_in_if  in_ch ();
  bca_out_if out_ch ();

  braille_chord_accumulator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Shadow of the block's key state. Held keys lose an entry by moving the last one
  // into the freed slot; the chord keeps press order so the last nav key can be found.
  logic [4:0]  keys_down [LIST_DEPTH];
  int unsigned keys_down_n;
  logic [4:0]  chord_order [LIST_DEPTH];
  int unsigned chord_len;

  key_result_t pending_results[$];
  int unsigned events_sent;
  int unsigned errors;
  bit          in_gaps_on;
  bit          out_stalls_on;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Most gaps are zero or a few cycles; now and then a long one. With idling switched
  // off no gap is ever taken, so the block also sees back-to-back traffic.
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] press_of(input logic [6:0] code);
    return {1'b0, code};
  endfunction

  function automatic logic [7:0] release_of(input logic [6:0] code);
    return KEY_RELEASE | {1'b0, code};
  endfunction

  function automatic bit list_has(input logic [4:0] list [LIST_DEPTH], input int unsigned n,
                                  input logic [4:0] code);
    for (int unsigned i = 0; i < n; i++)
      if (list[i] == code) return 1'b1;
    return 1'b0;
  endfunction

  // Advances the shadow state by one accepted event and queues the result it causes.
  function automatic void predict_key_result(input logic cmd, input logic [7:0] kb);
    logic        released;
    logic [6:0]  code;
    logic [6:0]  offset;
    logic [4:0]  key;
    key_result_t res;
    released = kb[7];
    code     = kb[6:0];
    key      = kb[4:0];
    res      = '0;
    if (cmd == CMD_CLEAR) begin
      keys_down_n = 0;
      chord_len   = 0;
    end else if (code >= ROUTE_LO && code < ROUTE_END) begin
      // Routing keys answer on press only.
      if (!released) begin
        offset    = code - ROUTE_LO;
        res.kind  = KIND_ROUTE;
        res.route = offset[5:0];
        pending_results.push_back(res);
      end
    end else if (code < ROUTE_LO) begin
      if (!released) begin
        if (!list_has(keys_down, keys_down_n, key) && keys_down_n < LIST_DEPTH) begin
          keys_down[keys_down_n] = key;
          keys_down_n++;
        end
        if (!list_has(chord_order, chord_len, key) && chord_len < LIST_DEPTH) begin
          chord_order[chord_len] = key;
          chord_len++;
        end
      end else begin
        for (int unsigned i = 0; i < keys_down_n; i++) begin
          if (keys_down[i] == key) begin
            keys_down_n--;
            keys_down[i] = keys_down[keys_down_n];
            break;
          end
        end
        // The chord completes when the last held key goes up, even if the released
        // code itself was never held.
        if (keys_down_n == 0 && chord_len != 0) begin
          res.kind = KIND_CHORD;
          for (int unsigned i = 0; i < chord_len; i++) begin
            case (chord_order[i])
              CODE_DOT1: res.dots[0] = 1'b1;
              CODE_DOT2: res.dots[1] = 1'b1;
              CODE_DOT3: res.dots[2] = 1'b1;
              CODE_DOT4: res.dots[3] = 1'b1;
              CODE_DOT5: res.dots[4] = 1'b1;
              CODE_DOT6: res.dots[5] = 1'b1;
              CODE_DOT7: res.dots[6] = 1'b1;
              CODE_DOT8: res.dots[7] = 1'b1;
              CODE_SPACE: res.space = 1'b1;
              CODE_NAV_A, CODE_NAV_B, CODE_NAV_C, CODE_NAV_D: res.nav = chord_order[i];
              default: ;
            endcase
          end
          chord_len = 0;
          pending_results.push_back(res);
        end
      end
    end
    // Codes of 0x48 and above fall through with no effect.
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // Presents one event from a falling edge on, after an optional gap, and returns at the
  // rising edge of its transfer. Valid stays high into the next call, so back-to-back
  // events only change the payload.
  task automatic send_event(input logic cmd, input logic [7:0] kb);
    int unsigned gap;
    gap = pick_gap(in_gaps_on);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.key_byte <= kb;
    do @(posedge clk); while (!in_ch.ready);
    predict_key_result(cmd, kb);
    events_sent++;
  endtask

  // Result receiver: ready drops for random stretches when stalls are switched on.
  initial begin : drive_ready
    int unsigned hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = pick_gap(out_stalls_on);
      end
    end
  end

  // Every result transfer is matched against the oldest queued expectation.
  always @(posedge clk) begin : check_results
    key_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with none expected: kind %0d dots 0x%02h route %0d",
                                  out_ch.result_kind, out_ch.dot_mask, out_ch.routing_index));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.result_kind !== want.kind)
          report_mismatch($sformatf("result_kind got %0d want %0d",
                                    out_ch.result_kind, want.kind));
        if (out_ch.dot_mask !== want.dots)
          report_mismatch($sformatf("dot_mask got 0x%02h want 0x%02h",
                                    out_ch.dot_mask, want.dots));
        if (out_ch.space_pressed !== want.space)
          report_mismatch($sformatf("space_pressed got %0d want %0d",
                                    out_ch.space_pressed, want.space));
        if (out_ch.nav_code !== want.nav)
          report_mismatch($sformatf("nav_code got 0x%02h want 0x%02h",
                                    out_ch.nav_code, want.nav));
        if (out_ch.routing_index !== want.route)
          report_mismatch($sformatf("routing_index got %0d want %0d",
                                    out_ch.routing_index, want.route));
      end
    end
  end

  // A transfer on either channel clears the quiet count; at STALL_LIMIT the run is hung.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n && !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready))
        quiet++;
      else
        quiet = 0;
    end
    $display("status: fail");
    $finish;
  end

  // Routing extremes, a routing release, and dropped high codes with and without the
  // release bit.
  task automatic test_routing_keys();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    send_event(CMD_KEY, press_of(ROUTE_LO));
    send_event(CMD_KEY, press_of(ROUTE_END - 7'd1));
    send_event(CMD_KEY, release_of(ROUTE_END - 7'd1));
    send_event(CMD_KEY, press_of(ROUTE_END));
    send_event(CMD_KEY, press_of(CODE_TOP));
    send_event(CMD_KEY, release_of(CODE_TOP));
    send_event(CMD_KEY, release_of(ROUTE_END));
  endtask

  // One chord with two dot extremes, space, an unmapped key, a repeated press, a release
  // of a key that is not held, and two nav keys of which the later one must win. Then a
  // chord made only of an unmapped key, and a release with no chord open. No idling here.
  task automatic test_chord_keys();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    send_event(CMD_KEY, press_of(CODE_DOT1));
    send_event(CMD_KEY, press_of(CODE_DOT8));
    send_event(CMD_KEY, press_of(CODE_SPACE));
    send_event(CMD_KEY, press_of(CODE_NAV_A));
    send_event(CMD_KEY, press_of(CODE_NAV_D));
    send_event(CMD_KEY, press_of(KEY_UNMAPPED_A));
    send_event(CMD_KEY, press_of(CODE_DOT1));
    send_event(CMD_KEY, release_of(CODE_DOT2));
    send_event(CMD_KEY, release_of(CODE_NAV_A));
    send_event(CMD_KEY, release_of(CODE_DOT1));
    send_event(CMD_KEY, release_of(CODE_DOT8));
    send_event(CMD_KEY, release_of(CODE_SPACE));
    send_event(CMD_KEY, release_of(CODE_NAV_D));
    send_event(CMD_KEY, release_of(KEY_UNMAPPED_A));
    send_event(CMD_KEY, press_of(KEY_UNMAPPED_B));
    send_event(CMD_KEY, release_of(KEY_UNMAPPED_B));
    send_event(CMD_KEY, release_of(CODE_DOT3));
  endtask

  // A clear in the middle of a chord drops it, whatever its key byte holds.
  task automatic test_clear();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    send_event(CMD_KEY, press_of(CODE_DOT3));
    send_event(CMD_CLEAR, 8'hFF);
    send_event(CMD_KEY, release_of(CODE_DOT3));
  endtask

  function automatic logic [4:0] pick_chord_code();
    if ($urandom_range(0, 9) < 7) return NAMED_KEYS[$urandom_range(0, NAMED_COUNT - 1)];
    return 5'($urandom_range(0, 31));
  endfunction

  // Mostly well-formed chords: keys pressed, then released in shuffled order, with
  // repeats, routing and dropped codes mixed in. A few chords press LIST_DEPTH keys or more.
  // Short bursts of raw noise, each often followed by a clear, fill out the rest.
  task automatic test_random_chords();
    logic [4:0]  codes[$];
    logic [4:0]  swap;
    int unsigned n;
    int unsigned r;
    int unsigned k;
    while (events_sent < RANDOM_EVENTS) begin
      r = $urandom_range(0, 3);
      in_gaps_on    = r[0];
      out_stalls_on = r[1];
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4))
          send_event(($urandom_range(0, 9) == 0) ? CMD_CLEAR : CMD_KEY, 8'($urandom));
        if ($urandom_range(0, 1) == 0) send_event(CMD_CLEAR, 8'($urandom));
      end
      r = $urandom_range(0, 99);
      if (r < 85)      n = $urandom_range(1, 6);
      else if (r < 95) n = $urandom_range(7, 15);
      else             n = $urandom_range(LIST_DEPTH, LIST_DEPTH + 4);
      codes.delete();
      for (int unsigned i = 0; i < n; i++) codes.push_back(pick_chord_code());
      for (int unsigned i = 0; i < n; i++) begin
        send_event(CMD_KEY, press_of({2'b00, codes[i]}));
        r = $urandom_range(0, 99);
        if (r < 8)
          send_event(CMD_KEY, press_of({2'b00, codes[$urandom_range(0, i)]}));
        else if (r < 13)
          send_event(CMD_KEY, {1'($urandom_range(0, 1)),
                               ROUTE_LO + 7'($urandom_range(0, 39))});
        else if (r < 16)
          send_event(CMD_KEY, {1'($urandom_range(0, 1)),
                               7'($urandom_range(ROUTE_END, CODE_TOP))});
        else if (r < 17)
          send_event(CMD_CLEAR, 8'($urandom));
      end
      for (int unsigned i = n; i > 1; i--) begin
        k = $urandom_range(0, i - 1);
        swap = codes[i - 1];
        codes[i - 1] = codes[k];
        codes[k] = swap;
      end
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 5)
          send_event(CMD_KEY, release_of({2'b00, pick_chord_code()}));
        send_event(CMD_KEY, release_of({2'b00, codes[i]}));
      end
    end
  endtask

  initial begin : run_tests
    errors        = 0;
    events_sent   = 0;
    keys_down_n   = 0;
    chord_len     = 0;
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.command  = CMD_KEY;
    in_ch.key_byte = 8'h00;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_routing_keys();
    test_chord_keys();
    test_clear();
    test_random_chords();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    // Wait for every queued result, then give the block time to show anything extra.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/bca_pkg.sv
design/bca_in_if.sv
design/bca_out_if.sv
design/bca_ctrl.sv
design/bca_dpath.sv
design/braille_chord_accumulator.sv
bench/tb_braille_chord_accumulator.sv
